// ===== hdl/lrr_pkg.sv =====
// shared types and constants for the longest run with replacements block
`default_nettype none
package lrr_pkg;

  localparam int SYM_W      = 5;
  localparam int LEN_W      = 13;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OQ_PW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_MAX_CHANGES = reg_idx_t'(0);

  typedef struct packed {
    logic [LEN_W-1:0] longest;
    logic             too_long;
  } res_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
  } apb_req_t;

endpackage
`default_nettype wire

// ===== hdl/lrr_ifs.sv =====
// symbol and result channel interfaces
`default_nettype none
interface lrr_sym_if import lrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface lrr_res_if import lrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] longest;
  logic             too_long;

  modport source (output valid, output longest, output too_long, input ready);
  modport sink (input valid, input longest, input too_long, output ready);
endinterface
`default_nettype wire

// ===== hdl/lrr_ram.sv =====
// generic single write port ram with registered read-first read port
`default_nettype none
module lrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/lrr_apb.sv =====
// apb register bank holding the replacement limit
`default_nettype none
module lrr_apb import lrr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire apb_req_t          req,
  output logic      [DATA_W-1:0] prdata,
  output logic      [LEN_W-1:0]  max_changes
);

  logic [LEN_W-1:0] mc_r;
  logic [LEN_W-1:0] mc_nxt;
  reg_idx_t         idx;
  logic             wr;

  always_comb begin
    idx    = req.paddr[ADDR_W-1:2];
    wr     = req.psel && req.penable && req.pwrite;
    mc_nxt = mc_r;
    prdata = '0;
    unique case (idx)
      REG_MAX_CHANGES: begin
        prdata = {{(DATA_W-LEN_W){1'b0}}, mc_r};
        if (wr) begin
          mc_nxt = req.pwdata[LEN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r <= '0;
    end else begin
      mc_r <= mc_nxt;
    end
  end

  assign max_changes = mc_r;

endmodule
`default_nettype wire

// ===== hdl/lrr_outq.sv =====
// result queue between the count pipeline and the result channel
`default_nettype none
module lrr_outq import lrr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire res_t             push_data,
  output logic      [OQ_CW-1:0] occ,
  lrr_res_if.source             out_if
);

  res_t             q_r [OUTQ_DEPTH];
  logic [OQ_PW-1:0] wp_r;
  logic [OQ_PW-1:0] wp_nxt;
  logic [OQ_PW-1:0] rp_r;
  logic [OQ_PW-1:0] rp_nxt;
  logic [OQ_CW-1:0] occ_r;
  logic [OQ_CW-1:0] occ_nxt;
  logic             pop;
  res_t             head;

  always_comb begin
    pop     = out_if.valid && out_if.ready;
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    occ_nxt = occ_r;
    if (push && !pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (pop && !push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      occ_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  assign head            = q_r[rp_r];
  assign occ             = occ_r;
  assign out_if.valid    = (occ_r != '0);
  assign out_if.longest  = head.longest;
  assign out_if.too_long = head.too_long;

endmodule
`default_nettype wire

// ===== hdl/longest_run_with_replacements.sv =====
// top level: sliding window letter count engine for longest run with replacements
//
//  port     | dir | beat contents            | handshake
//  in_if    | in  | symbol, last             | valid / ready
//  out_if   | out | longest, too_long        | valid / ready
//  cfg_*    | in  | max_changes at offset 0  | apb, pready tied high
//
// one symbol beat taken per cycle while ready; results pass stage one and the result queue
// the count read-modify-write reads at accept and writes in stage one, with forwarding
// evictions update their count rams in the following cycle, forwarded into the next symbol
// reset does not clear the count rams: per-letter valid flags stand in for clearing them
// input stalls while run_r is low or the four-beat queue has no room for a pending result
`default_nettype none
module longest_run_with_replacements import lrr_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lrr_sym_if.sink                in_if,
  lrr_res_if.source              out_if,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW     = $clog2(ALPHABET);
  localparam int RW     = $clog2(MAX_LEN);
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int CMPW   = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam int SYMX_W = 9;

  localparam logic [CW-1:0]     LEN_MAX   = CW'(MAX_LEN);
  localparam logic [RW-1:0]     RING_LAST = RW'(MAX_LEN - 1);
  localparam logic [SYMX_W-1:0] ALPH_X    = SYMX_W'(ALPHABET);

  function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] i);
    ring_next = (i == RING_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [ALPHABET-1:0] letter_bit(input logic [AW-1:0] i);
    letter_bit = {{(ALPHABET-1){1'b0}}, 1'b1} << i;
  endfunction

  apb_req_t         apb_req;
  logic [LEN_W-1:0] max_changes;
  logic [OQ_CW-1:0] occ;
  logic [OQ_CW-1:0] occ_sum;
  res_t             res;

  logic run_r;
  logic acc;
  logic [SYMX_W-1:0] sym_x;
  logic [AW-1:0]     sym0;
  logic              ok0;

  logic          s1_v_r, s1_v_nxt;
  logic          s1_last_r;
  logic          s1_ok_r;
  logic [AW-1:0] s1_sym_r;

  logic [CW-1:0] win_r, win_nxt, win_upd;
  logic [CW-1:0] top_r, top_nxt, top_new;
  logic [CW-1:0] sc_r, sc_nxt;
  logic          ovf_r, ovf_nxt, ovf_upd;
  logic [RW-1:0] left_r, left_nxt;
  logic [RW-1:0] wr_r, wr_nxt, wr_base;

  logic          la_v_r, la_v_nxt;
  logic [AW-1:0] la_addr_r;
  logic [CW-1:0] la_data_r;
  logic          ld_v_r, ld_v_nxt;
  logic [AW-1:0] ld_addr_r;
  logic [CW-1:0] ld_data_r;
  logic [ALPHABET-1:0] va_r, va_nxt;
  logic [ALPHABET-1:0] vd_r, vd_nxt;

  logic          s2_v_r, s2_v_nxt;
  logic [AW-1:0] s2_old_r;

  logic [CW-1:0] a_rd, dsym_rd, dold_rd;
  logic [AW-1:0] ring_rd;

  logic [CW-1:0]   fwd_a, fwd_d, cnt_new, a_wdata, d_old_cnt, d_wdata;
  logic            full, old_hit, evict2, upd, ev, clr, grows;
  logic [CMPW-1:0] grow, lim, win_x;

  assign apb_req = '{psel: cfg_psel, penable: cfg_penable, pwrite: cfg_pwrite,
                     paddr: cfg_paddr, pwdata: cfg_pwdata};
  assign cfg_pready = 1'b1;

  lrr_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (apb_req),
    .prdata      (cfg_prdata),
    .max_changes (max_changes)
  );

  // input side
  assign occ_sum     = occ + {{(OQ_CW-1){1'b0}}, clr};
  assign in_if.ready = run_r && (occ_sum < OQ_CW'(OUTQ_DEPTH));
  assign acc         = in_if.valid && in_if.ready;
  assign sym_x       = {{(SYMX_W-SYM_W){1'b0}}, in_if.symbol};
  assign sym0        = sym_x[AW-1:0];
  assign ok0         = (sym_x < ALPH_X);

  // stage one: count update and eviction decision
  always_comb begin
    if (la_v_r && (la_addr_r == s1_sym_r)) begin
      fwd_a = la_data_r;
    end else begin
      fwd_a = va_r[s1_sym_r] ? a_rd : '0;
    end
    if (s2_v_r && (s2_old_r == s1_sym_r)) begin
      fwd_d = d_wdata;
    end else if (ld_v_r && (ld_addr_r == s1_sym_r)) begin
      fwd_d = ld_data_r;
    end else begin
      fwd_d = vd_r[s1_sym_r] ? dsym_rd : '0;
    end
    full    = (win_r == LEN_MAX);
    old_hit = full && (ring_rd == s1_sym_r);
    a_wdata = fwd_a + 1'b1;
    cnt_new = a_wdata - fwd_d - {{(CW-1){1'b0}}, old_hit};
    top_new = (cnt_new > top_r) ? cnt_new : top_r;
    grow    = {{(CMPW-CW){1'b0}}, win_r} + 1'b1;
    lim     = {{(CMPW-CW){1'b0}}, top_new} + {{(CMPW-LEN_W){1'b0}}, max_changes};
    evict2  = !full && (grow > lim);
    upd     = s1_v_r && s1_ok_r;
    ev      = upd && (full || evict2);
    clr     = s1_v_r && s1_last_r;
    grows   = upd && !full && !evict2;

    win_upd = grows ? win_r + 1'b1 : win_r;
    win_nxt = clr ? '0 : win_upd;
    top_nxt = clr ? '0 : (upd ? top_new : top_r);
    sc_nxt  = sc_r;
    if (clr) begin
      sc_nxt = '0;
    end else if (upd && (sc_r != LEN_MAX)) begin
      sc_nxt = sc_r + 1'b1;
    end
    ovf_upd  = ovf_r || (upd && (sc_r == LEN_MAX));
    ovf_nxt  = clr ? 1'b0 : ovf_upd;
    left_nxt = clr ? '0 : (ev ? ring_next(left_r) : left_r);
    wr_base  = clr ? '0 : wr_r;
    wr_nxt   = (acc && ok0) ? ring_next(wr_base) : wr_base;

    la_v_nxt = !clr && (upd || la_v_r);
    va_nxt   = clr ? '0 : (va_r | (upd ? letter_bit(s1_sym_r) : '0));
    s2_v_nxt = ev && !s1_last_r;
    s1_v_nxt = acc;

    // stage two: eviction count write
    if (ld_v_r && (ld_addr_r == s2_old_r)) begin
      d_old_cnt = ld_data_r;
    end else begin
      d_old_cnt = vd_r[s2_old_r] ? dold_rd : '0;
    end
    d_wdata  = d_old_cnt + 1'b1;
    ld_v_nxt = !clr && (s2_v_r || ld_v_r);
    vd_nxt   = clr ? '0 : (vd_r | (s2_v_r ? letter_bit(s2_old_r) : '0));

    win_x        = {{(CMPW-CW){1'b0}}, win_upd};
    res.longest  = win_x[LEN_W-1:0];
    res.too_long = ovf_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      la_v_r <= 1'b0;
      ld_v_r <= 1'b0;
      va_r   <= '0;
      vd_r   <= '0;
      win_r  <= '0;
      top_r  <= '0;
      sc_r   <= '0;
      ovf_r  <= 1'b0;
      left_r <= '0;
      wr_r   <= '0;
    end else begin
      run_r  <= 1'b1;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      la_v_r <= la_v_nxt;
      ld_v_r <= ld_v_nxt;
      va_r   <= va_nxt;
      vd_r   <= vd_nxt;
      win_r  <= win_nxt;
      top_r  <= top_nxt;
      sc_r   <= sc_nxt;
      ovf_r  <= ovf_nxt;
      left_r <= left_nxt;
      wr_r   <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_if.last;
    s1_ok_r   <= ok0;
    s1_sym_r  <= sym0;
    s2_old_r  <= ring_rd;
    if (upd) begin
      la_addr_r <= s1_sym_r;
      la_data_r <= a_wdata;
    end
    if (s2_v_r) begin
      ld_addr_r <= s2_old_r;
      ld_data_r <= d_wdata;
    end
  end

  // ring of window symbols
  lrr_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_ring (
    .clk   (clk),
    .we    (acc && ok0),
    .waddr (wr_base),
    .wdata (sym0),
    .raddr (left_nxt),
    .rdata (ring_rd)
  );

  // symbols added per letter
  lrr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_cnt_add (
    .clk   (clk),
    .we    (upd),
    .waddr (s1_sym_r),
    .wdata (a_wdata),
    .raddr (sym0),
    .rdata (a_rd)
  );

  // symbols evicted per letter, two copies for the two read addresses
  lrr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_cnt_ev_sym (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_old_r),
    .wdata (d_wdata),
    .raddr (sym0),
    .rdata (dsym_rd)
  );

  lrr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_cnt_ev_old (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_old_r),
    .wdata (d_wdata),
    .raddr (ring_rd),
    .rdata (dold_rd)
  );

  lrr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (clr),
    .push_data (res),
    .occ       (occ),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire

// ===== hdl/lrr_checker.sv =====
// port-level checker for the longest run with replacements block, with its bind
`default_nettype none
module lrr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result beat without an accepted last symbol");

endmodule

bind longest_run_with_replacements lrr_checker u_lrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_last   (in_if.last),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);
`default_nettype wire

// ===== bench/lrr_run_checker.sv =====
// checker: predicts the longest run per string from the symbol beats and compares results
`timescale 1ns / 1ps
module lrr_run_checker import lrr_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  lrr_sym_if                sym_mon,
  lrr_res_if                res_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output int                mismatches,
  output int                runs_checked,
  output int                runs_due
);

  localparam int PTR_W = $clog2(MAX_LEN);

  logic [LEN_W-1:0] max_changes;
  logic [LEN_W-1:0] letter_tally [ALPHABET];
  logic [SYM_W-1:0] window_ring [MAX_LEN];
  logic [LEN_W-1:0] win_len;
  logic [LEN_W-1:0] top_tally;
  logic [LEN_W-1:0] best_len;
  logic [LEN_W-1:0] accepted;
  logic [PTR_W-1:0] left_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic             overflow;
  res_t             run_results_due [$];

  function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void clear_string();
    foreach (letter_tally[i]) letter_tally[i] = '0;
    win_len   = '0;
    top_tally = '0;
    best_len  = '0;
    accepted  = '0;
    left_ptr  = '0;
    write_ptr = '0;
    overflow  = 1'b0;
  endfunction

  function automatic void drop_left_edge();
    logic [SYM_W-1:0] old;
    old = window_ring[left_ptr];
    if (old < ALPHABET && letter_tally[old] > 0) letter_tally[old]--;
    left_ptr = ring_step(left_ptr);
    win_len--;
  endfunction

  function automatic void take_symbol(input logic [SYM_W-1:0] sym, input logic tail);
    res_t due;
    if (sym < ALPHABET) begin
      if (accepted > MAX_LEN - 1) overflow = 1'b1;
      if (accepted <= MAX_LEN) accepted++;
      if (win_len >= MAX_LEN) drop_left_edge();
      window_ring[write_ptr] = sym;
      write_ptr = ring_step(write_ptr);
      win_len++;
      letter_tally[sym]++;
      if (letter_tally[sym] > top_tally) top_tally = letter_tally[sym];
      if ((LEN_W+1)'(win_len) > (LEN_W+1)'(top_tally) + (LEN_W+1)'(max_changes))
        drop_left_edge();
      if (win_len > best_len) best_len = win_len;
    end
    if (tail) begin
      due.longest  = (best_len > MAX_LEN) ? LEN_W'(MAX_LEN) : best_len;
      due.too_long = overflow;
      run_results_due.push_back(due);
      clear_string();
    end
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      max_changes = '0;
      clear_string();
      run_results_due.delete();
      mismatches   = 0;
      runs_checked = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          reg_idx_t'(cfg_paddr >> 2) == REG_MAX_CHANGES)
        max_changes = cfg_pwdata[LEN_W-1:0];
      if (sym_mon.valid && sym_mon.ready) take_symbol(sym_mon.symbol, sym_mon.last);
      if (res_mon.valid && res_mon.ready) begin
        if (run_results_due.size() == 0) begin
          report($sformatf("result beat with no string finished: longest %0d too_long %0d",
                           res_mon.longest, res_mon.too_long));
        end else begin
          want = run_results_due.pop_front();
          runs_checked++;
          if (res_mon.longest !== want.longest)
            report($sformatf("longest got %0d, expected %0d", res_mon.longest, want.longest));
          if (res_mon.too_long !== want.too_long)
            report($sformatf("too_long got %0d, expected %0d", res_mon.too_long,
                             want.too_long));
        end
      end
    end
    runs_due = run_results_due.size();
  end

endmodule

// ===== bench/longest_run_with_replacements_tb.sv =====
// testbench top: symbol stimulus, result back-pressure, register writes and verdict
`timescale 1ns / 1ps
module longest_run_with_replacements_tb import lrr_pkg::*; ();

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;
  localparam int LIMIT    = 500000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int send_idle;
  int recv_idle;
  int letters_sent;
  int beats_sent;
  int strings_sent;
  int cycle_count;
  int mismatches;
  int runs_checked;
  int runs_due;

  lrr_sym_if sym_bus ();
  lrr_res_if res_bus ();

  longest_run_with_replacements #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (sym_bus),
    .out_if      (res_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lrr_run_checker #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) run_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .sym_mon      (sym_bus),
    .res_mon      (res_bus),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .mismatches   (mismatches),
    .runs_checked (runs_checked),
    .runs_due     (runs_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding", cycle_count, runs_due);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_beat(input logic [SYM_W-1:0] sym, input logic tail);
    while ($urandom_range(99) < send_idle) begin
      sym_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sym_bus.valid  <= 1'b1;
    sym_bus.symbol <= sym;
    sym_bus.last   <= tail;
    @(posedge clk);
    while (!sym_bus.ready) @(posedge clk);
    beats_sent++;
    if (sym < ALPHABET) letters_sent++;
    if (tail) strings_sent++;
  endtask

  task automatic send_string(input int len, input int palette, input int noise_pct);
    logic [SYM_W-1:0] s;
    int               base;
    base = $urandom_range(0, ALPHABET - 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct)
        s = SYM_W'($urandom_range(ALPHABET, 31));
      else
        s = SYM_W'((base + $urandom_range(0, palette - 1)) % ALPHABET);
      send_beat(s, i == len - 1);
    end
  endtask

  task automatic run_random(input int letters);
    int start;
    int len;
    int palette;
    start = letters_sent;
    while (letters_sent - start < letters) begin
      if ($urandom_range(99) < 3) begin
        send_beat(SYM_W'($urandom_range(ALPHABET, 31)), 1'b1);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        palette = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, ALPHABET);
        send_string(len, palette, 4);
      end
    end
  endtask

  task automatic write_max_changes(input logic [LEN_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_MAX_CHANGES, 2'b00};
    cfg_pwdata  <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic settle();
    sym_bus.valid <= 1'b0;
    @(posedge clk);
    while (runs_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    send_idle    = 32;
    recv_idle    = 83;
    letters_sent = 0;
    beats_sent   = 0;
    strings_sent = 0;
    rst_n          <= 1'b0;
    sym_bus.valid  <= 1'b0;
    sym_bus.symbol <= '0;
    sym_bus.last   <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings with one replacement allowed
    write_max_changes(LEN_W'(1));
    send_beat(SYM_W'(31), 1'b1);
    send_beat(SYM_W'(0), 1'b1);
    send_beat(SYM_W'(25), 1'b1);
    send_beat(SYM_W'(0), 1'b0);
    send_beat(SYM_W'(0), 1'b0);
    send_beat(SYM_W'(1), 1'b0);
    send_beat(SYM_W'(0), 1'b0);
    send_beat(SYM_W'(1), 1'b0);
    send_beat(SYM_W'(1), 1'b0);
    send_beat(SYM_W'(0), 1'b1);
    send_beat(SYM_W'(26), 1'b0);
    send_beat(SYM_W'(21), 1'b0);
    send_beat(SYM_W'(10), 1'b0);
    send_beat(SYM_W'(21), 1'b0);
    send_beat(SYM_W'(31), 1'b1);
    settle();

    write_max_changes(LEN_W'(0));
    run_random(460);
    settle();

    send_idle = 83;
    recv_idle = 32;
    write_max_changes(LEN_W'(3));
    run_random(420);
    settle();

    // replacement limits at and above the largest window
    send_idle = 0;
    recv_idle = 0;
    write_max_changes(LEN_W'(8191));
    run_random(250);
    settle();

    write_max_changes(LEN_W'(MAX_LEN));
    run_random(230);
    settle();

    $display("sent %0d strings in %0d symbol beats (%0d letters) over five max_changes values",
             strings_sent, beats_sent, letters_sent);
    $display("checked %0d results, %0d mismatches", runs_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
